// File: rtl/core/cxs_pkg.sv
// ============================================================================
// cxs_pkg: shared constants and elaboration-time functions
// Matrix coefficients, datapath widths and the gamma threshold generator.
// ============================================================================
`default_nettype none

package cxs_pkg;

    localparam int GAMMA_INDEX_BITS_DEF = 12;

    // Width of a scaled gamma threshold: T (up to 2^32) times (2^16 - 1).
    localparam int THR_W = 49;

    // Divider geometry.
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 16;

    // Signed widths of the colour matrix path.
    localparam int XYZ_W  = 35;
    localparam int COEF_W = 19;
    localparam int PROD_W = XYZ_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    typedef logic signed [COEF_W-1:0] coef_t;

    // sRGB D65 matrix in Q16, rows R, G, B; columns X, Y, Z.
    localparam coef_t M_RX = 19'sd212376;
    localparam coef_t M_RY = -19'sd100742;
    localparam coef_t M_RZ = -19'sd32676;
    localparam coef_t M_GX = -19'sd63498;
    localparam coef_t M_GY = 19'sd122932;
    localparam coef_t M_GZ = 19'sd2720;
    localparam coef_t M_BX = 19'sd3650;
    localparam coef_t M_BY = -19'sd13369;
    localparam coef_t M_BZ = 19'sd69272;

    // Products of Q32 values, truncated back to Q32.
    function automatic logic [127:0] qmul32(input logic [127:0] a, input logic [127:0] b);
        logic [127:0] p;
        p = a * b;
        return p >> 32;
    endfunction

    // Linear-light threshold of output code k, scaled by (2^gbits - 1).
    // Evaluated only at elaboration to fill constant tables.
    function automatic logic [THR_W-1:0] gamma_thr(input int k, input int gbits);
        logic [127:0] a;
        logic [127:0] a2;
        logic [127:0] r;
        logic [127:0] t;
        logic [127:0] p;
        logic [127:0] thr;
        logic [127:0] gmax;
        gmax = (128'd1 << gbits) - 128'd1;
        if (k == 0)
        begin
            thr = '0;
        end
        else if (k <= 10)
        begin
            thr = ((128'(k) * 128'd100) << 32) / 128'd329460;
        end
        else
        begin
            a = ((128'(k) * 128'd1000 + 128'd14025) << 32) / 128'd269025;
            if (a > 128'hFFFF_FFFF)
            begin
                a = 128'hFFFF_FFFF;
            end
            a2 = qmul32(a, a);
            r = '0;
            for (int s = 31; s >= 0; s--)
            begin
                t = r | (128'd1 << s);
                p = qmul32(qmul32(qmul32(qmul32(t, t), t), t), t);
                if (p <= a2)
                begin
                    r = t;
                end
            end
            thr = qmul32(a2, r);
        end
        return THR_W'(thr * gmax);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cxs_divider.sv
// ============================================================================
// cxs_divider: pipelined restoring divider
// One quotient bit per register stage; the stages advance only when en is high.
// ============================================================================
`default_nettype none

module cxs_divider #(
    parameter int NUM_W = cxs_pkg::DIV_NUM_W,
    parameter int DEN_W = cxs_pkg::DIV_DEN_W
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quot
);

    logic [DEN_W-1:0] rem_reg  [NUM_W];
    logic [NUM_W-1:0] work_reg [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] work_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] work_next;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign work_in = num;
            assign den_in  = den;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign work_in = work_reg[i-1];
            assign den_in  = den_reg[i-1];
        end

        assign trial = {rem_in, work_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};

        // For a non-zero divisor the remainder stays below it, so DEN_W bits hold it.
        always_comb
        begin
            if (trial >= {1'b0, den_in})
            begin
                rem_next  = diff[DEN_W-1:0];
                work_next = {work_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_W-1:0];
                work_next = {work_in[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                work_reg[i] <= work_next;
                den_reg[i]  <= den_in;
            end
        end
    end

    assign quot = work_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: rtl/core/cxs_gamma.sv
// ============================================================================
// cxs_gamma: pipelined sRGB transfer curve lookup
// Binary search over the 255 code thresholds, one result bit per stage.
// ============================================================================
`default_nettype none

module cxs_gamma #(
    parameter int GAMMA_INDEX_BITS = cxs_pkg::GAMMA_INDEX_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [GAMMA_INDEX_BITS-1:0] idx,
    output logic      [7:0]                  code
);

    localparam int GB    = GAMMA_INDEX_BITS;
    localparam int STEPS = 8;

    logic [cxs_pkg::THR_W-1:0] thr_tab [256];

    for (genvar k = 0; k < 256; k++)
    begin : g_thr
        localparam logic [cxs_pkg::THR_W-1:0] THR_K = cxs_pkg::gamma_thr(k, GB);
        assign thr_tab[k] = THR_K;
    end

    logic [7:0]    code_reg [STEPS];
    logic [GB-1:0] idx_reg  [STEPS];

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic [7:0]                code_in;
        logic [GB-1:0]             idx_in;
        logic [7:0]                cand;
        logic [cxs_pkg::THR_W-1:0] key;
        logic [7:0]                code_next;

        if (j == 0)
        begin : g_first
            assign code_in = '0;
            assign idx_in  = idx;
        end
        else
        begin : g_rest
            assign code_in = code_reg[j-1];
            assign idx_in  = idx_reg[j-1];
        end

        assign cand = code_in | (8'd1 << (STEPS - 1 - j));
        assign key  = {{(cxs_pkg::THR_W - 32 - GB){1'b0}}, idx_in, 32'd0};
        assign code_next = (thr_tab[cand] <= key) ? cand : code_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                code_reg[j] <= code_next;
                idx_reg[j]  <= idx_in;
            end
        end
    end

    assign code = code_reg[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/core/cie_xy_to_srgb.sv
// ============================================================================
// cie_xy_to_srgb: CIE xyY to 8-bit sRGB (D65) colour converter
// Fully pipelined: chromaticity and brightness in, gamma-corrected RGB out.
// ============================================================================
//
//  Channel  Direction  Fields (lowest bit first)
//  -------  ---------  -------------------------------------------------
//  s_*      in         tdata: chroma_x[15:0], chroma_y[31:16], brightness[39:32]
//  m_*      out        tdata: red[7:0], green[15:8], blue[23:16]
//
// One request enters every clock cycle while the output is not stalled; the
// pipeline depth is set mostly by the 34-stage restoring divider which
// forms X and Z, plus the eight-stage binary search of the gamma curve.
// All stages move together; a stalled result holds the whole pipeline, so
// the input is ready whenever the output register is empty or being taken.
// Reset clears only the stage valid bits; the data registers are not reset.
//
`default_nettype none

module cie_xy_to_srgb #(
    parameter int GAMMA_INDEX_BITS = cxs_pkg::GAMMA_INDEX_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // chroma_x, chroma_y, brightness
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red, green, blue
);

    localparam int GB    = GAMMA_INDEX_BITS;
    localparam int DIVW  = cxs_pkg::DIV_NUM_W;
    localparam int XW    = cxs_pkg::XYZ_W;
    localparam int PW    = cxs_pkg::PROD_W;
    localparam int SW    = cxs_pkg::SUM_W;
    // Input stage, numerator stage, divider, five matrix/index stages, search.
    localparam int LAT   = 2 + DIVW + 5 + 8;
    localparam logic [GB-1:0] GMAX = {GB{1'b1}};

    typedef struct packed {
        logic [16:0] cy;
        logic        zneg;
        logic        yzero;
    } side_t;

    // The whole pipeline advances together.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 0: capture the request and form Y = max(bri,5) * 65536 / 255.
    // Since 65536 = 255 * 257 + 1, the quotient is b * 257, plus one at 255.
    // ------------------------------------------------------------------
    logic [15:0] x0_reg, y0_reg;
    logic [16:0] cy0_reg;
    logic [7:0]  bri_clamp;
    logic [16:0] cy_next;

    assign bri_clamp = (s_tdata[39:32] < 8'd5) ? 8'd5 : s_tdata[39:32];
    assign cy_next   = 17'(bri_clamp) * 17'd257 + 17'(bri_clamp == 8'd255);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg  <= s_tdata[15:0];
            y0_reg  <= s_tdata[31:16];
            cy0_reg <= cy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: numerators Y*x and |Y*(1-x-y)|, sign kept on the side.
    // ------------------------------------------------------------------
    logic signed [17:0] one_m_xy;
    logic [16:0]        omxy_mag;
    logic [DIVW-1:0]    numx1_reg, numz1_reg;
    logic [15:0]        den1_reg;
    side_t              side1_reg;

    assign one_m_xy = 18'sh10000 - $signed({2'b00, x0_reg}) - $signed({2'b00, y0_reg});
    assign omxy_mag = one_m_xy[17] ? 17'(-one_m_xy) : one_m_xy[16:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numx1_reg       <= DIVW'(cy0_reg) * DIVW'(x0_reg);
            numz1_reg       <= DIVW'(cy0_reg) * DIVW'(omxy_mag);
            den1_reg        <= y0_reg;
            side1_reg.cy    <= cy0_reg;
            side1_reg.zneg  <= one_m_xy[17];
            side1_reg.yzero <= (y0_reg == 16'd0);
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: X and Z quotients, side data delayed alongside.
    // ------------------------------------------------------------------
    logic [DIVW-1:0] qx, qz;

    cxs_divider #(.NUM_W(DIVW), .DEN_W(cxs_pkg::DIV_DEN_W)) u_div_x (
        .clk  (clk),
        .en   (adv),
        .num  (numx1_reg),
        .den  (den1_reg),
        .quot (qx)
    );

    cxs_divider #(.NUM_W(DIVW), .DEN_W(cxs_pkg::DIV_DEN_W)) u_div_z (
        .clk  (clk),
        .en   (adv),
        .num  (numz1_reg),
        .den  (den1_reg),
        .quot (qz)
    );

    side_t side_reg [DIVW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side1_reg;
            for (int i = 1; i < DIVW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Signed X, Y, Z; Z truncates toward zero, so negate the magnitude.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx_reg, cy_reg, cz_reg;
    side_t                sd;

    assign sd = side_reg[DIVW-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cy_reg <= $signed(XW'(sd.cy));
            if (sd.yzero)
            begin
                cx_reg <= '0;
                cz_reg <= '0;
            end
            else
            begin
                cx_reg <= $signed(XW'(qx));
                cz_reg <= sd.zneg ? -$signed(XW'(qz)) : $signed(XW'(qz));
            end
        end
    end

    // ------------------------------------------------------------------
    // Matrix: nine registered products, then three registered sums (Q32).
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_reg [9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= cx_reg * cxs_pkg::M_RX;
            prod_reg[1] <= cy_reg * cxs_pkg::M_RY;
            prod_reg[2] <= cz_reg * cxs_pkg::M_RZ;
            prod_reg[3] <= cx_reg * cxs_pkg::M_GX;
            prod_reg[4] <= cy_reg * cxs_pkg::M_GY;
            prod_reg[5] <= cz_reg * cxs_pkg::M_GZ;
            prod_reg[6] <= cx_reg * cxs_pkg::M_BX;
            prod_reg[7] <= cy_reg * cxs_pkg::M_BY;
            prod_reg[8] <= cz_reg * cxs_pkg::M_BZ;
        end
    end

    logic signed [SW-1:0] sum_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= SW'(prod_reg[3*c]) + SW'(prod_reg[3*c+1])
                            + SW'(prod_reg[3*c+2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp each channel to 0..1, scale to a table index, round and clip.
    // ------------------------------------------------------------------
    logic [16:0]    clip [3];
    logic [16+GB:0] idxp_reg [3];
    logic [GB+1:0]  idx_round [3];
    logic [GB-1:0]  idx_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (sum_reg[c][SW-1])
            begin
                clip[c] = '0;
            end
            else if (sum_reg[c] > $signed(SW'(64'h1_0000_0000)))
            begin
                clip[c] = 17'h10000;
            end
            else
            begin
                clip[c] = sum_reg[c][32:16];
            end
            idx_round[c] = (GB+2)'((idxp_reg[c] + (17+GB)'(32768)) >> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                idxp_reg[c] <= (17+GB)'(clip[c]) * (17+GB)'(GMAX);
                idx_reg[c]  <= (idx_round[c] > (GB+2)'(GMAX)) ? GMAX
                                                               : idx_round[c][GB-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Transfer curve; the final search stage is the output register.
    // ------------------------------------------------------------------
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        cxs_gamma #(.GAMMA_INDEX_BITS(GB)) u_gamma (
            .clk  (clk),
            .en   (adv),
            .idx  (idx_reg[c]),
            .code (m_tdata[8*c +: 8])
        );
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // While a result is held back, the pipeline valid bits may not move.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during an output stall");

    // X is a quotient of non-negative values and must never come out negative.
    a_cx_positive: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIVW+2] |-> !cx_reg[XW-1])
        else $error("X came out of the divider negative");

endmodule

`default_nettype wire
